@@ design/rank_one_coordinate_update_macros.svh @@
// Assertion macros shared by the rank-one coordinate update block.
`ifndef RANK_ONE_COORDINATE_UPDATE_MACROS_SVH
`define RANK_ONE_COORDINATE_UPDATE_MACROS_SVH

// check a condition in the same cycle as its trigger
`define ROC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the cycle after its trigger
`define ROC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/roc_pkg.sv @@
// Package: shared widths, defaults, queue sizing and back-end state type.
`timescale 1ns / 1ps

package roc_pkg;

	localparam int DATA_W       = 32;
	localparam int ACC_W        = 64;
	localparam int MAX_NZ_DEF   = 65536;
	localparam int FRAC_DEF     = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEPS    = DATA_W;
	localparam int ITER_W       = $clog2(DIV_STEPS);

	localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic empty;
		logic ovf;
	} job_flags_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ADD,
		B_PREP,
		B_DIV,
		B_FIN,
		B_DONE
	} back_state_t;

endpackage

@@ design/roc_if.sv @@
// Interfaces: input item, result item and register write channels.
`timescale 1ns / 1ps

interface roc_item_if import roc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] factor_value;
	logic signed [DATA_W-1:0] rating_value;
	logic                     last_in_column;
	logic                     empty_column;

	modport source (output valid, factor_value, rating_value, last_in_column, empty_column,
		input ready);
	modport sink (input valid, factor_value, rating_value, last_in_column, empty_column,
		output ready);
endinterface

interface roc_result_if import roc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] new_factor;
	logic                     saturated;

	modport source (output valid, new_factor, saturated, input ready);
	modport sink (input valid, new_factor, saturated, output ready);
endinterface

interface roc_cfg_if import roc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] reg_weight;

	modport source (output valid, reg_weight, input ready);
	modport sink (input valid, reg_weight, output ready);
endinterface

@@ design/roc_fifo.sv @@
// Short job queue between the accumulating front end and the dividing back end.
`timescale 1ns / 1ps

module roc_fifo import roc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule

@@ design/roc_front.sv @@
// Front end: accepts nonzeros, forms products and keeps the column sums.
`timescale 1ns / 1ps

module roc_front import roc_pkg::*; #(
	parameter int MAX_COLUMN_NONZEROS = MAX_NZ_DEF,
	parameter int FRACTION_BITS       = FRAC_DEF,
	parameter int CNT_W               = $clog2(MAX_COLUMN_NONZEROS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	roc_item_if.sink                 items,
	input  logic [QCNT_W-1:0]        fifo_cnt,
	output logic                     job_push,
	output logic signed [ACC_W-1:0]  job_g,
	output logic signed [ACC_W-1:0]  job_h,
	output logic [CNT_W-1:0]         job_cnt,
	output job_flags_t               job_flags
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMN_NONZEROS);

	logic                    valid_s1;
	logic                    last_s1;
	logic                    empty_s1;
	logic signed [ACC_W-1:0] prod_ur_s1;
	logic signed [ACC_W-1:0] prod_uu_s1;

	logic signed [ACC_W-1:0] g_q;
	logic signed [ACC_W-1:0] h_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;

	logic                    accept;
	logic                    term;
	logic [ACC_W:0]          add_g;
	logic [ACC_W:0]          add_h;
	logic [CNT_W-1:0]        cnt_next;
	logic                    cnt_sat;
	logic                    ovf_next;

	function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		logic [ACC_W:0]          r;
		s = a + b;
		if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
			r = {1'b1, a[ACC_W-1] ? S64_MIN : S64_MAX};
		end else begin
			r = {1'b0, s};
		end
		return r;
	endfunction

	assign term   = valid_s1 & (last_s1 | empty_s1);
	assign accept = items.valid & items.ready;
	assign items.ready = ((QCNT_W+1)'(fifo_cnt) + (QCNT_W+1)'(term))
		< (QCNT_W+1)'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= items.last_in_column;
			empty_s1   <= items.empty_column;
			prod_ur_s1 <= items.factor_value * items.rating_value;
			prod_uu_s1 <= items.factor_value * items.factor_value;
		end
	end

	always_comb begin
		add_g    = sat_add(g_q, prod_ur_s1 >>> FRACTION_BITS);
		add_h    = sat_add(h_q, prod_uu_s1 >>> FRACTION_BITS);
		cnt_sat  = (cnt_q >= CNT_MAX);
		cnt_next = cnt_sat ? CNT_MAX : cnt_q + CNT_W'(1);
		ovf_next = ovf_q | add_g[ACC_W] | add_h[ACC_W] | cnt_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q   <= '0;
			h_q   <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1) begin
			if (term) begin
				g_q   <= '0;
				h_q   <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				g_q   <= add_g[ACC_W-1:0];
				h_q   <= add_h[ACC_W-1:0];
				cnt_q <= cnt_next;
				ovf_q <= ovf_next;
			end
		end
	end

	assign job_push        = term;
	assign job_g           = add_g[ACC_W-1:0];
	assign job_h           = add_h[ACC_W-1:0];
	assign job_cnt         = cnt_next;
	assign job_flags.empty = empty_s1;
	assign job_flags.ovf   = ovf_next;

endmodule

@@ design/roc_back.sv @@
// Back end: forms the denominator and divides one bit a cycle into the result.
`timescale 1ns / 1ps

module roc_back import roc_pkg::*; #(
	parameter int MAX_COLUMN_NONZEROS = MAX_NZ_DEF,
	parameter int FRACTION_BITS       = FRAC_DEF,
	parameter int CNT_W               = $clog2(MAX_COLUMN_NONZEROS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [DATA_W-1:0]        reg_weight,
	input  logic                     job_valid,
	input  logic signed [ACC_W-1:0]  job_g,
	input  logic signed [ACC_W-1:0]  job_h,
	input  logic [CNT_W-1:0]         job_cnt,
	input  job_flags_t               job_flags,
	output logic                     job_pop,
	roc_result_if.source             results
);

	localparam int SH     = DATA_W - FRACTION_BITS;
	localparam int PROD_W = DATA_W + CNT_W;

	back_state_t state_q;
	back_state_t state_next;

	logic signed [ACC_W-1:0] g_q;
	logic signed [ACC_W-1:0] h_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    flag_q;
	logic [PROD_W-1:0]       prod_q;
	logic [ACC_W-1:0]        den_q;
	logic [ACC_W-1:0]        rem_q;
	logic [DATA_W-1:0]       low_q;
	logic [DATA_W-1:0]       quo_q;
	logic [ITER_W-1:0]       iter_q;
	logic [DATA_W-1:0]       fin_factor_q;
	logic                    fin_sat_q;
	logic                    res_valid_q;
	logic [DATA_W-1:0]       res_factor_q;
	logic                    res_sat_q;

	logic                    res_load;
	logic                    neg;
	logic [ACC_W-1:0]        mag;
	logic                    den_zero;
	logic                    quo_ovf;
	logic [ACC_W-1:0]        h_pos;
	logic [ACC_W:0]          den_sum;
	logic [ACC_W:0]          shifted;
	logic                    step_ge;
	logic [DATA_W-1:0]       lim;

	always_comb begin
		neg      = g_q[ACC_W-1];
		mag      = neg ? (~g_q + ACC_W'(1)) : g_q;
		den_zero = (den_q == '0);
		quo_ovf  = ((mag >> SH) >= den_q);
		h_pos    = h_q[ACC_W-1] ? '0 : h_q;
		den_sum  = (ACC_W+1)'(prod_q) + (ACC_W+1)'(h_pos);
		shifted  = {rem_q, low_q[DATA_W-1]};
		step_ge  = (shifted >= {1'b0, den_q});
		lim      = neg ? NEG_LIM : POS_LIM;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_pop) begin
					state_next = job_flags.empty ? B_DONE : B_MUL;
				end
			end
			B_MUL:  state_next = B_ADD;
			B_ADD:  state_next = B_PREP;
			B_PREP: state_next = (den_zero || quo_ovf) ? B_DONE : B_DIV;
			B_DIV: begin
				if (iter_q == '0) begin
					state_next = B_FIN;
				end
			end
			B_FIN:  state_next = B_DONE;
			B_DONE: begin
				if (res_load) begin
					state_next = B_IDLE;
				end
			end
			default: state_next = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		res_load = 1'b0;
		case (state_q)
			B_IDLE:  job_pop  = job_valid;
			B_DONE:  res_load = !res_valid_q || results.ready;
			default: begin
				job_pop  = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_pop) begin
					g_q          <= job_g;
					h_q          <= job_h;
					cnt_q        <= job_cnt;
					flag_q       <= job_flags.ovf;
					fin_factor_q <= '0;
					fin_sat_q    <= 1'b0;
				end
			end
			B_MUL: prod_q <= reg_weight * cnt_q;
			B_ADD: begin
				if (den_sum[ACC_W:ACC_W-1] != '0) begin
					den_q  <= S64_MAX;
					flag_q <= 1'b1;
				end else begin
					den_q  <= den_sum[ACC_W-1:0];
				end
			end
			B_PREP: begin
				if (den_zero) begin
					fin_factor_q <= '0;
					fin_sat_q    <= 1'b1;
				end else if (quo_ovf) begin
					fin_factor_q <= lim;
					fin_sat_q    <= 1'b1;
				end else begin
					rem_q  <= mag >> SH;
					low_q  <= {mag[SH-1:0], {FRACTION_BITS{1'b0}}};
					quo_q  <= '0;
					iter_q <= ITER_W'(DIV_STEPS - 1);
				end
			end
			B_DIV: begin
				rem_q  <= step_ge ? ACC_W'(shifted - {1'b0, den_q}) : shifted[ACC_W-1:0];
				low_q  <= low_q << 1;
				quo_q  <= {quo_q[DATA_W-2:0], step_ge};
				iter_q <= iter_q - ITER_W'(1);
			end
			B_FIN: begin
				if (quo_q > lim) begin
					fin_factor_q <= neg ? (~lim + DATA_W'(1)) : lim;
					fin_sat_q    <= 1'b1;
				end else begin
					fin_factor_q <= neg ? (~quo_q + DATA_W'(1)) : quo_q;
					fin_sat_q    <= flag_q;
				end
			end
			B_DONE: begin
				if (res_load) begin
					res_factor_q <= fin_factor_q;
					res_sat_q    <= fin_sat_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign results.valid      = res_valid_q;
	assign results.new_factor = res_factor_q;
	assign results.saturated  = res_sat_q;

endmodule

@@ design/rank_one_coordinate_update.sv @@
// Top level: rank-one coordinate update with register, job queue and assertions.
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    factor_value, rating_value, last_in_column, empty_column
//  results   out  valid/ready    new_factor, saturated
//  cfg       in   valid/ready    reg_weight
//
//  Nonzeros enter one per cycle while items are ready; each is registered in the multiply stage, then accumulates.
//  A column end queues a job; the back end takes one job at a time through multiply, add,
//  prepare, divide and finish, with a bit-serial divider (one quotient bit per cycle, 32 bits).
//  Up to four column ends wait in the queue; items stall when the count plus a job being pushed reaches four.
//  Reset clears the sums, count, queue, back-end state and the weight register.
`timescale 1ns / 1ps
`include "rank_one_coordinate_update_macros.svh"

module rank_one_coordinate_update import roc_pkg::*; #(
	parameter int MAX_COLUMN_NONZEROS = MAX_NZ_DEF,
	parameter int FRACTION_BITS       = FRAC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	roc_item_if.sink      items,
	roc_result_if.source  results,
	roc_cfg_if.sink       cfg
);

	localparam int CNT_W = $clog2(MAX_COLUMN_NONZEROS + 1);
	localparam int JOB_W = 2 * ACC_W + CNT_W + $bits(job_flags_t);

	logic [DATA_W-1:0]       reg_weight_q;

	logic                    job_push;
	logic signed [ACC_W-1:0] push_g;
	logic signed [ACC_W-1:0] push_h;
	logic [CNT_W-1:0]        push_cnt;
	job_flags_t              push_flags;

	logic                    job_pop;
	logic                    fifo_empty;
	logic [QCNT_W-1:0]       fifo_cnt;
	logic [QCNT_W-1:0]       cnt_expect;
	logic [JOB_W-1:0]        rd_job;
	logic signed [ACC_W-1:0] pop_g;
	logic signed [ACC_W-1:0] pop_h;
	logic [CNT_W-1:0]        pop_cnt;
	job_flags_t              pop_flags;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_weight_q <= '0;
		end else if (cfg.valid) begin
			reg_weight_q <= cfg.reg_weight;
		end
	end

	roc_front #(
		.MAX_COLUMN_NONZEROS (MAX_COLUMN_NONZEROS),
		.FRACTION_BITS       (FRACTION_BITS),
		.CNT_W               (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.fifo_cnt  (fifo_cnt),
		.job_push  (job_push),
		.job_g     (push_g),
		.job_h     (push_h),
		.job_cnt   (push_cnt),
		.job_flags (push_flags)
	);

	roc_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data ({push_g, push_h, push_cnt, push_flags}),
		.pop     (job_pop),
		.rd_data (rd_job),
		.empty   (fifo_empty),
		.count   (fifo_cnt)
	);

	assign {pop_g, pop_h, pop_cnt, pop_flags} = rd_job;

	roc_back #(
		.MAX_COLUMN_NONZEROS (MAX_COLUMN_NONZEROS),
		.FRACTION_BITS       (FRACTION_BITS),
		.CNT_W               (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.reg_weight (reg_weight_q),
		.job_valid  (!fifo_empty),
		.job_g      (pop_g),
		.job_h      (pop_h),
		.job_cnt    (pop_cnt),
		.job_flags  (pop_flags),
		.job_pop    (job_pop),
		.results    (results)
	);

	assign cnt_expect = fifo_cnt + QCNT_W'(job_push) - QCNT_W'(job_pop);

	`ROC_ASSERT_SAME(a_push_room, job_push, fifo_cnt < QCNT_W'(QUEUE_DEPTH), "job queue overrun")
	`ROC_ASSERT_SAME(a_pop_held, job_pop, fifo_cnt != '0, "job popped from empty queue")
	`ROC_ASSERT_NEXT(a_cnt_track, 1'b1, fifo_cnt == $past(cnt_expect), "job queue count drift")

endmodule

@@ bench/testbench.sv @@
// Testbench for rank_one_coordinate_update: directed table and random columns.
`timescale 1ns / 1ps

module testbench import roc_pkg::*; ();

	localparam int          FRAC               = FRAC_DEF;
	localparam int unsigned NZ_CAP             = MAX_NZ_DEF;
	localparam int          DRAIN_CYCLES       = 64;
	localparam int          RANDOM_PHASE_ITEMS = 250;

	typedef struct {
		logic signed [DATA_W-1:0] factor_value;
		logic signed [DATA_W-1:0] rating_value;
		logic                     last_in_column;
		logic                     empty_column;
	} nonzero_t;

	typedef struct {
		logic signed [DATA_W-1:0] new_factor;
		logic                     saturated;
	} factor_t;

	typedef enum {ROW_ITEM, ROW_WEIGHT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		nonzero_t          nz;
		logic [DATA_W-1:0] weight;
		bit                typed;
		factor_t           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	roc_item_if   items_if ();
	roc_result_if results_if ();
	roc_cfg_if    cfg_if ();

	rank_one_coordinate_update i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	logic [DATA_W-1:0]       weight_q;
	logic signed [ACC_W-1:0] g_acc;
	logic signed [ACC_W-1:0] h_acc;
	int unsigned             nz_count;
	bit                      ovf_seen;
	factor_t                 pending_factors[$];
	factor_t                 unused_factor;
	int                      errors = 0;
	int                      send_quiet = 0;
	int                      recv_quiet = 0;

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void clear_column();
		g_acc    = '0;
		h_acc    = '0;
		nz_count = 0;
		ovf_seen = 1'b0;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			ovf_seen = 1'b1;
			return a[ACC_W-1] ? S64_MIN : S64_MAX;
		end
		return s;
	endfunction

	// accumulate one nonzero or clear on an empty item; return 1 when the column closes with a new factor
	function automatic bit update_column(input nonzero_t nz, output factor_t res);
		logic signed [ACC_W-1:0] fu;
		logic signed [ACC_W-1:0] fr;
		logic signed [ACC_W-1:0] g;
		logic [ACC_W-1:0]        den;
		logic [ACC_W-1:0]        mag;
		logic [ACC_W+FRAC-1:0]   quo;
		logic [DATA_W-1:0]       lim;
		bit                      flag;
		bit                      neg;
		res.new_factor = '0;
		res.saturated  = 1'b0;
		if (nz.empty_column) begin
			clear_column();
			return 1'b1;
		end
		fu = nz.factor_value;
		fr = nz.rating_value;
		g_acc = sat_sum(g_acc, (fu * fr) >>> FRAC);
		h_acc = sat_sum(h_acc, (fu * fu) >>> FRAC);
		if (nz_count >= NZ_CAP) begin
			nz_count = NZ_CAP;
			ovf_seen = 1'b1;
		end else begin
			nz_count++;
		end
		if (!nz.last_in_column)
			return 1'b0;
		flag = ovf_seen;
		den  = ACC_W'(weight_q) * ACC_W'(nz_count);
		if (h_acc > 0) begin
			if (den > S64_MAX - h_acc) begin
				den  = S64_MAX;
				flag = 1'b1;
			end else begin
				den = den + h_acc;
			end
		end
		g = g_acc;
		clear_column();
		if (den == 0) begin
			res.saturated = 1'b1;
			return 1'b1;
		end
		neg = g[ACC_W-1];
		mag = neg ? -g : g;
		quo = {mag, {FRAC{1'b0}}} / {{FRAC{1'b0}}, den};
		lim = neg ? NEG_LIM : POS_LIM;
		if (quo > lim) begin
			quo  = lim;
			flag = 1'b1;
		end
		res.new_factor = neg ? -quo[DATA_W-1:0] : quo[DATA_W-1:0];
		res.saturated  = flag;
		return 1'b1;
	endfunction

	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 5);
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_q16();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return POS_LIM;
					1: return NEG_LIM;
					2: return '0;
					default: return '1;
				endcase
			end
			6, 7: return $urandom_range(0, 32'hFFFFFF) - 32'h800000;
			default: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
		endcase
	endfunction

	function automatic stim_row_t item_row(input logic [DATA_W-1:0] f, input logic [DATA_W-1:0] r,
		input logic last, input logic empty);
		stim_row_t row;
		row.kind                = ROW_ITEM;
		row.nz.factor_value     = f;
		row.nz.rating_value     = r;
		row.nz.last_in_column   = last;
		row.nz.empty_column     = empty;
		row.weight              = '0;
		row.typed               = 1'b0;
		row.want.new_factor     = '0;
		row.want.saturated      = 1'b0;
		return row;
	endfunction

	function automatic stim_row_t checked_row(input logic [DATA_W-1:0] f,
		input logic [DATA_W-1:0] r, input logic last, input logic empty,
		input logic [DATA_W-1:0] exp_factor, input logic exp_sat);
		stim_row_t row;
		row                 = item_row(f, r, last, empty);
		row.typed           = 1'b1;
		row.want.new_factor = exp_factor;
		row.want.saturated  = exp_sat;
		return row;
	endfunction

	function automatic stim_row_t weight_row(input logic [DATA_W-1:0] w);
		stim_row_t row;
		row        = item_row('0, '0, 1'b0, 1'b0);
		row.kind   = ROW_WEIGHT;
		row.weight = w;
		return row;
	endfunction

	task automatic send_nonzero(input nonzero_t nz, input bit typed, input factor_t want);
		factor_t res;
		int      gap;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid          <= 1'b1;
		items_if.factor_value   <= nz.factor_value;
		items_if.rating_value   <= nz.rating_value;
		items_if.last_in_column <= nz.last_in_column;
		items_if.empty_column   <= nz.empty_column;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		if (update_column(nz, res))
			pending_factors.push_back(typed ? want : res);
	endtask

	// hold the sender until every new factor is out and the back end is quiet
	task automatic settle();
		items_if.valid <= 1'b0;
		while (pending_factors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_weight(input logic [DATA_W-1:0] w);
		settle();
		cfg_if.valid      <= 1'b1;
		cfg_if.reg_weight <= w;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		weight_q = w;
	endtask

	// well-formed columns mostly; some empty items, some columns cut short by an empty item
	task automatic send_random_column(output int sent);
		nonzero_t nz;
		int       len;
		sent = 0;
		case ($urandom_range(0, 9))
			0: len = 0;
			1: len = $urandom_range(7, 40);
			default: len = $urandom_range(1, 6);
		endcase
		if (len == 0) begin
			nz.factor_value   = $urandom;
			nz.rating_value   = $urandom;
			nz.last_in_column = $urandom_range(0, 1);
			nz.empty_column   = 1'b1;
			send_nonzero(nz, 1'b0, unused_factor);
			sent = 1;
			return;
		end
		for (int k = 0; k < len; k++) begin
			nz.factor_value   = draw_q16();
			nz.rating_value   = draw_q16();
			nz.last_in_column = (k == len - 1);
			nz.empty_column   = 1'b0;
			if ($urandom_range(0, 29) == 0) begin
				nz.empty_column   = 1'b1;
				nz.last_in_column = $urandom_range(0, 1);
			end
			send_nonzero(nz, 1'b0, unused_factor);
			sent++;
			if (nz.empty_column)
				return;
		end
	endtask

	initial begin
		factor_t want;
		int      stall;
		results_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid) @(posedge clk);
			if (pending_factors.size() == 0) begin
				$error("new_factor: expected none, got %h", results_if.new_factor);
				errors++;
			end else begin
				want = pending_factors.pop_front();
				if (results_if.new_factor !== want.new_factor) begin
					$error("new_factor: expected %h, got %h", want.new_factor,
						results_if.new_factor);
					errors++;
				end
				if (results_if.saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated,
						results_if.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t         rows[$];
		logic [DATA_W-1:0] phase_weights[5];
		int                sent;
		int                n;
		items_if.valid          <= 1'b0;
		items_if.factor_value   <= '0;
		items_if.rating_value   <= '0;
		items_if.last_in_column <= 1'b0;
		items_if.empty_column   <= 1'b0;
		cfg_if.valid            <= 1'b0;
		cfg_if.reg_weight       <= '0;
		weight_q = '0;
		clear_column();
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(checked_row(32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b1, 32'h0, 1'b0));
		rows.push_back(checked_row(32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 1'b1));
		rows.push_back(checked_row(32'h10000, 32'h20000, 1'b1, 1'b0, 32'h20000, 1'b0));
		rows.push_back(checked_row(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, 32'h10000, 1'b0));
		rows.push_back(checked_row(32'h80000000, 32'h80000000, 1'b1, 1'b0, 32'h10000, 1'b0));
		rows.push_back(item_row(32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0));
		rows.push_back(checked_row(32'h100, 32'h7FFFFFFF, 1'b1, 1'b0, 32'h7FFFFFFF, 1'b1));
		rows.push_back(checked_row(32'h100, 32'h80000000, 1'b1, 1'b0, 32'h80000000, 1'b1));
		rows.push_back(item_row(32'h12345, 32'h6789, 1'b0, 1'b0));
		rows.push_back(checked_row(32'hFFFFFFFF, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0));
		rows.push_back(item_row(32'h10000, 32'h10000, 1'b0, 1'b0));
		rows.push_back(item_row(32'hFFFF0000, 32'h30000, 1'b1, 1'b0));
		rows.push_back(weight_row(32'hFFFFFFFF));
		rows.push_back(checked_row(32'h0, 32'h7FFFFFFF, 1'b1, 1'b0, 32'h0, 1'b0));
		rows.push_back(item_row(32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0));
		rows.push_back(item_row(32'h10000, 32'hFFFFFFFF, 1'b1, 1'b0));
		rows.push_back(weight_row(32'h10000));
		rows.push_back(checked_row(32'h10000, 32'h30000, 1'b1, 1'b0, 32'h18000, 1'b0));
		rows.push_back(checked_row(32'h10000, 32'hFFFD0000, 1'b1, 1'b0, 32'hFFFE8000, 1'b0));
		rows.push_back(item_row(32'h3, 32'hFFFFFFFF, 1'b0, 1'b0));
		rows.push_back(item_row(32'h2AAAA, 32'h5, 1'b1, 1'b0));
		rows.push_back(checked_row(32'h55555555, 32'hAAAAAAAA, 1'b0, 1'b1, 32'h0, 1'b0));
		rows.push_back(weight_row(32'h1));
		rows.push_back(checked_row(32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0));
		rows.push_back(item_row(32'h8000, 32'hFFFF8000, 1'b1, 1'b0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WEIGHT)
				write_weight(rows[i].weight);
			else
				send_nonzero(rows[i].nz, rows[i].typed, rows[i].want);
		end

		phase_weights[0] = $urandom;
		phase_weights[1] = $urandom_range(0, 32'h40000);
		phase_weights[2] = '0;
		phase_weights[3] = '1;
		phase_weights[4] = $urandom_range(1, 32'hFFFF);
		foreach (phase_weights[p]) begin
			write_weight(phase_weights[p]);
			sent = 0;
			while (sent < RANDOM_PHASE_ITEMS) begin
				send_random_column(n);
				sent += n;
			end
		end

		settle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
